>>> hw/rtl/dba_pkg.sv
// Shared types and constants for the depth band average unit.
package dba_pkg;

  localparam int BANDS_DEF      = 8;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int DEPTH_W     = 16;
  localparam int SUM_W       = 34;
  localparam int CNT_W       = 18;
  localparam int BAND_OUT_W  = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int WIDTH_CFG_W = 11;
  localparam int ROW_CFG_W   = 10;

  localparam logic [CNT_W-1:0]       COUNT_MAX     = '1;
  localparam logic [DEPTH_W-1:0]     MIN_REL_RST   = 16'd500;
  localparam logic [DEPTH_W-1:0]     MAX_REL_RST   = 16'd4500;
  localparam logic [WIDTH_CFG_W-1:0] WIDTH_RST     = 11'd512;
  localparam logic [ROW_CFG_W-1:0]   START_ROW_RST = 10'd212;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RELIABLE = 2'd0,
    REG_MAX_RELIABLE = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2,
    REG_START_ROW    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic rd_sel;
    logic div_load;
    logic div_step;
    logic clear;
  } dba_cmd_t;

endpackage

>>> hw/rtl/dba_datapath.sv
// Datapath: configuration, pixel position tracking, band accumulators and divider.
module dba_datapath
  import dba_pkg::*;
#(
  parameter int BANDS      = BANDS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int AW = (BANDS > 1) ? $clog2(BANDS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  pix_accept,
  input  logic [DEPTH_W-1:0]    in_depth,
  input  dba_cmd_t              cmd,
  input  logic [AW-1:0]         band_sel,
  output logic [DEPTH_W-1:0]    average
);

  localparam int BIW   = $clog2(BANDS + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int LB    = $clog2(BANDS);
  localparam int SH    = WW + LB;
  localparam int PW    = SH + WW + 1;
  localparam int CLW   = (WW > WIDTH_CFG_W) ? WW : WIDTH_CFG_W;
  localparam int RLW   = (RW > ROW_CFG_W) ? RW : ROW_CFG_W;
  localparam int ENT_W = SUM_W + CNT_W;
  localparam longint unsigned RECIP_L = ((longint'(1) << SH) + BANDS - 1) / BANDS;
  localparam logic [PW-1:0] RECIP = PW'(RECIP_L);
  localparam int W_RST_I = (int'(WIDTH_RST) > MAX_WIDTH) ? MAX_WIDTH : int'(WIDTH_RST);
  localparam logic [WW-1:0] W_RST  = WW'(W_RST_I);
  localparam logic [WW-1:0] BW_RST = WW'(W_RST_I / BANDS);

  logic [DEPTH_W-1:0]   min_r, max_r;
  logic [WW-1:0]        w_r, bw_r;
  logic [ROW_CFG_W-1:0] start_r;

  logic [CW-1:0]  col_r;
  logic [WW-1:0]  sub_r;
  logic [BIW-1:0] band_r;
  logic [RW-1:0]  row_r;

  logic [ENT_W-1:0]   mem [BANDS];
  logic [BANDS-1:0]   vld_r;
  logic [ENT_W-1:0]   rd_data_r;
  logic               rd_vld_r;
  logic [AW-1:0]      rd_addr_r;
  logic               s1_valid_r;
  logic               s1_hit_r;
  logic [DEPTH_W-1:0] s1_depth_r;
  logic               fwd_en_r;
  logic [AW-1:0]      fwd_addr_r;
  logic [ENT_W-1:0]   fwd_data_r;

  logic [CNT_W-1:0]   rem_r;
  logic [DEPTH_W-1:0] quo_r;
  logic [CNT_W-1:0]   div_cnt_r;
  logic               zero_r;

  logic [CLW-1:0]   w_cfg;
  logic [WW-1:0]    w_new;
  logic [PW-1:0]    prod;
  logic [WW-1:0]    bw_new;
  logic             row_ok, region, in_range, hit0;
  logic [AW-1:0]    pix_addr, rd_addr;
  logic [WW-1:0]    col_inc;
  logic [ENT_W-1:0] ent;
  logic [SUM_W-1:0] ent_sum;
  logic [CNT_W-1:0] ent_cnt;
  logic             wr_en;
  logic [ENT_W-1:0] wr_data;
  logic [CNT_W:0]   div_t;
  logic             div_ge;

  assign w_cfg = CLW'(cfg_data[WIDTH_CFG_W-1:0]);

  always_comb begin
    if (w_cfg == '0) begin
      w_new = WW'(1);
    end else if (w_cfg > CLW'(MAX_WIDTH)) begin
      w_new = WW'(MAX_WIDTH);
    end else begin
      w_new = w_cfg[WW-1:0];
    end
  end

  // Band width is the clamped width times a rounded-up reciprocal of BANDS.
  assign prod   = PW'(w_new) * RECIP;
  assign bw_new = prod[SH +: WW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r   <= MIN_REL_RST;
      max_r   <= MAX_REL_RST;
      w_r     <= W_RST;
      bw_r    <= BW_RST;
      start_r <= START_ROW_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_RELIABLE: min_r <= cfg_data[DEPTH_W-1:0];
        REG_MAX_RELIABLE: max_r <= cfg_data[DEPTH_W-1:0];
        REG_IMAGE_WIDTH: begin
          w_r  <= w_new;
          bw_r <= bw_new;
        end
        REG_START_ROW:    start_r <= cfg_data[ROW_CFG_W-1:0];
        default:          min_r <= min_r;
      endcase
    end
  end

  assign row_ok   = RLW'(row_r) >= RLW'(start_r);
  assign region   = (bw_r != '0) && (band_r < BIW'(BANDS));
  assign in_range = (in_depth >= min_r) && (in_depth <= max_r);
  assign hit0     = row_ok && region && in_range;
  assign pix_addr = region ? band_r[AW-1:0] : '0;
  assign rd_addr  = cmd.rd_sel ? band_sel : pix_addr;
  assign col_inc  = WW'(col_r) + WW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      col_r  <= '0;
      sub_r  <= '0;
      band_r <= '0;
      row_r  <= '0;
    end else if (pix_accept) begin
      if (col_inc >= w_r) begin
        col_r  <= '0;
        sub_r  <= '0;
        band_r <= '0;
        if (row_r != RW'(MAX_HEIGHT - 1)) begin
          row_r <= row_r + RW'(1);
        end
      end else begin
        col_r <= col_inc[CW-1:0];
        if (region) begin
          if (sub_r == bw_r - WW'(1)) begin
            sub_r  <= '0;
            band_r <= band_r + BIW'(1);
          end else begin
            sub_r <= sub_r + WW'(1);
          end
        end
      end
    end
  end

  // The entry written in the previous cycle is not yet in the read data.
  always_comb begin
    if (fwd_en_r && fwd_addr_r == rd_addr_r) begin
      ent = fwd_data_r;
    end else if (rd_vld_r) begin
      ent = rd_data_r;
    end else begin
      ent = '0;
    end
  end

  assign ent_sum = ent[SUM_W-1:0];
  assign ent_cnt = ent[SUM_W +: CNT_W];
  assign wr_en   = s1_valid_r && s1_hit_r && (ent_cnt != COUNT_MAX);
  assign wr_data = {ent_cnt + CNT_W'(1), ent_sum + SUM_W'(s1_depth_r)};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[rd_addr_r] <= wr_data;
    end
    rd_data_r  <= mem[rd_addr];
    rd_vld_r   <= vld_r[rd_addr];
    rd_addr_r  <= rd_addr;
    s1_hit_r   <= hit0;
    s1_depth_r <= in_depth;
    fwd_addr_r <= wr_en ? rd_addr_r : fwd_addr_r;
    fwd_data_r <= wr_en ? wr_data : fwd_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      vld_r      <= '0;
      fwd_en_r   <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= pix_accept;
      if (wr_en) begin
        vld_r[rd_addr_r] <= 1'b1;
        fwd_en_r         <= 1'b1;
      end
    end
  end

  // Restoring division; the quotient always fits in the depth width.
  assign div_t  = {rem_r, quo_r[DEPTH_W-1]};
  assign div_ge = div_t >= {1'b0, div_cnt_r};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r     <= CNT_W'(ent_sum[SUM_W-1:DEPTH_W]);
      quo_r     <= ent_sum[DEPTH_W-1:0];
      div_cnt_r <= ent_cnt;
      zero_r    <= (ent_cnt == '0);
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? CNT_W'(div_t - {1'b0, div_cnt_r}) : div_t[CNT_W-1:0];
      quo_r <= {quo_r[DEPTH_W-2:0], div_ge};
    end
  end

  assign average = zero_r ? '0 : quo_r;

endmodule

>>> hw/rtl/dba_ctrl.sv
// Controller: pixel intake and the per-band readout sequence at frame end.
module dba_ctrl
  import dba_pkg::*;
#(
  parameter int BANDS = BANDS_DEF,
  localparam int AW = (BANDS > 1) ? $clog2(BANDS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_last,
  input  logic                  out_stall,
  output logic                  in_stall,
  output logic                  pix_accept,
  output logic                  out_valid,
  output logic [BAND_OUT_W-1:0] out_band,
  output logic                  out_last_band,
  output dba_cmd_t              cmd,
  output logic [AW-1:0]         band_sel
);

  localparam int STEP_W = $clog2(DEPTH_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DEPTH_W - 1);
  localparam logic [AW-1:0]     K_LAST    = AW'(BANDS - 1);

  typedef enum logic [2:0] {
    S_RUN,
    S_READ,
    S_LOAD,
    S_DIV,
    S_SHOW
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     k_r, k_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign in_stall      = !rst_n || (state_r != S_RUN);
  assign pix_accept    = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_band      = BAND_OUT_W'(k_r);
  assign out_last_band = (k_r == K_LAST);
  assign band_sel      = k_r;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    case (state_r)
      S_RUN: begin
        if (pix_accept && in_last) begin
          state_nxt = S_READ;
          k_nxt     = '0;
        end
      end
      S_READ: begin
        cmd.rd_sel = 1'b1;
        state_nxt  = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt     = S_SHOW;
          out_valid_nxt = 1'b1;
        end
      end
      S_SHOW: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (k_r == K_LAST) begin
            cmd.clear = 1'b1;
            state_nxt = S_RUN;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = S_READ;
          end
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      k_r         <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_last_starts_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (pix_accept && in_last) |=> (state_r == S_READ && k_r == '0))
    else $error("Last pixel did not start the readout at band zero.");

  a_final_band_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_band) |=> (state_r == S_RUN && !out_valid))
    else $error("Final band transfer did not return to pixel intake.");

  a_div_done_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && step_r == STEP_LAST) |=> (out_valid && $stable(k_r)))
    else $error("Divider finish did not present a result.");

  a_valid_only_show: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_SHOW && in_stall))
    else $error("Result presented outside the output state.");

endmodule

>>> hw/rtl/depth_band_average_unit.sv
// Top level of the depth band average unit.
// Depth pixels are taken one per cycle in raster order. After the transfer of
// the pixel marked last, the unit stops taking pixels and reads out one result
// per band, left to right: each band goes through one accumulator read, one
// divider load, 16 steps of the shared restoring divider, and an output state
// that holds while the output is stalled; pixel intake resumes after the last
// band. Accumulators clear as the last band's result is transferred.
module depth_band_average_unit
  import dba_pkg::*;
#(
  parameter int BANDS      = BANDS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DEPTH_W-1:0]    in_depth,
  input  logic                  in_last_pixel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BAND_OUT_W-1:0] out_band,
  output logic [DEPTH_W-1:0]    out_average,
  output logic                  out_last_band
);

  localparam int AW = (BANDS > 1) ? $clog2(BANDS) : 1;

  dba_cmd_t      cmd;
  logic [AW-1:0] band_sel;
  logic          pix_accept;

  dba_ctrl #(
    .BANDS(BANDS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last       (in_last_pixel),
    .out_stall     (out_stall),
    .in_stall      (in_stall),
    .pix_accept    (pix_accept),
    .out_valid     (out_valid),
    .out_band      (out_band),
    .out_last_band (out_last_band),
    .cmd           (cmd),
    .band_sel      (band_sel)
  );

  dba_datapath #(
    .BANDS      (BANDS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_accept (pix_accept),
    .in_depth   (in_depth),
    .cmd        (cmd),
    .band_sel   (band_sel),
    .average    (out_average)
  );

endmodule
